// ===== sv/mpps_pkg.sv =====
// Shared types and constants of the multi-period poll scheduler.
package mpps_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_GCD,
		ST_FINISH
	} state_t;

	localparam logic [1:0] CFG_POLLING_ENABLED  = 2'd0;
	localparam logic [1:0] CFG_INITIAL_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_FAULT_STATE_KEY  = 2'd2;

	localparam logic [1:0] FREG_NONE = 2'd0;
	localparam logic [1:0] FREG_1    = 2'd1;
	localparam logic [1:0] FREG_2    = 2'd2;
	localparam logic [1:0] FREG_3    = 2'd3;

	localparam logic [15:0] INTERVAL_RESET = 16'd100;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  entry_key;
		logic [15:0] poll_period;
	} in_item_t;

	typedef struct packed {
		logic        due;
		logic [3:0]  due_key;
		logic [1:0]  fault_register;
		logic [15:0] check_interval;
		logic        last;
	} out_item_t;

endpackage

// ===== sv/mpps_cell.sv =====
// One table cell: holds a poll entry and takes its neighbor's entry on each shift.
module mpps_cell #(
	parameter int PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   d_valid,
	input  logic [PERIOD_BITS-1:0] d_period,
	input  logic [PERIOD_BITS:0]   d_accum,
	output logic                   q_valid,
	output logic [PERIOD_BITS-1:0] q_period,
	output logic [PERIOD_BITS:0]   q_accum
);

	logic                   valid_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS:0]   accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			period_q <= d_period;
			accum_q  <= d_accum;
		end
	end

	assign q_valid  = valid_q;
	assign q_period = period_q;
	assign q_accum  = accum_q;

endmodule

// ===== sv/mpps_gcd.sv =====
// Binary GCD unit: one shift or subtract step per cycle on nonzero operands.
module mpps_gcd #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] result
);

	localparam int KB = $clog2(W + 1);

	logic         run_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [KB-1:0] k_q;
	logic [W-1:0] a_d;
	logic [W-1:0] b_d;
	logic [KB-1:0] k_d;
	logic         equal;

	assign equal  = (a_q == b_q);
	assign busy   = run_q;
	assign done   = run_q && equal;
	assign result = a_q << k_q;

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		k_d = k_q;
		if (!a_q[0] && !b_q[0]) begin
			a_d = a_q >> 1;
			b_d = b_q >> 1;
			k_d = k_q + 1'b1;
		end else if (!a_q[0]) begin
			a_d = a_q >> 1;
		end else if (!b_q[0]) begin
			b_d = b_q >> 1;
		end else if (a_q > b_q) begin
			a_d = (a_q - b_q) >> 1;
		end else begin
			b_d = (b_q - a_q) >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (run_q && equal) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (run_q && !equal) begin
			a_q <= a_d;
			b_q <= b_d;
			k_q <= k_d;
		end
	end

endmodule

// ===== sv/multi_period_poll_scheduler_top.sv =====
// Top level of the multi-period poll scheduler: controller, cell ring and GCD unit.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_item   (mpps_pkg::in_item_t)
//   out       out_valid / out_ready  out_item  (mpps_pkg::out_item_t)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An add, a remove or a firing tick is accepted, rotates the ring through all NUM_KEYS cells
// and then delivers the last item; an expiring fault-state entry holds the walk while it is
// reported under each fault register in turn. Other items go straight to the last item. An
// add also runs the GCD unit for each further valid entry. Reset needs no clearing pass. A
// stalled output holds the walk only when a due item must leave the pending stage.
module multi_period_poll_scheduler_top #(
	parameter int NUM_KEYS    = 16,
	parameter int PERIOD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpps_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mpps_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int KW = $clog2(NUM_KEYS);
	localparam logic [PERIOD_BITS:0] ACCUM_MAX = {(PERIOD_BITS + 1){1'b1}};

	mpps_pkg::state_t state_q, state_d;

	logic                   cv [NUM_KEYS];
	logic [PERIOD_BITS-1:0] cp [NUM_KEYS];
	logic [PERIOD_BITS:0]   ca [NUM_KEYS];

	logic                   shift;
	logic                   wb_valid;
	logic [PERIOD_BITS-1:0] wb_period;
	logic [PERIOD_BITS:0]   wb_accum;

	logic [1:0]             op_q;
	logic [3:0]             key_q;
	logic [PERIOD_BITS-1:0] per_q;
	logic [PERIOD_BITS-1:0] add_q;
	logic [PERIOD_BITS-1:0] g_q;
	logic [KW-1:0]          idx_q;
	logic [1:0]             sub_q;
	logic                   first_q;
	logic                   walk_end_q;
	logic                   anyv_acc_q;
	logic                   any_valid_q;
	logic                   upd_int_q;
	logic                   polling_q;
	logic [3:0]             fault_key_q;
	logic [PERIOD_BITS-1:0] interval_q;
	logic [PERIOD_BITS-1:0] elapsed_q;
	logic                   pend_valid_q;
	logic [3:0]             pend_key_q;
	logic [1:0]             pend_freg_q;
	logic                   out_valid_q;
	mpps_pkg::out_item_t    out_item_q;

	logic                   gcd_start;
	logic                   gcd_busy;
	logic                   gcd_done;
	logic [PERIOD_BITS-1:0] gcd_result;

	logic                   key_ok;
	logic [PERIOD_BITS-1:0] in_per;
	logic [PERIOD_BITS-1:0] elapsed_inc;
	logic                   tick_fire;
	logic                   idx_hit;
	logic                   fault_hit;
	logic                   last_idx;
	logic [PERIOD_BITS+1:0] sum;
	logic [PERIOD_BITS:0]   sat_accum;
	logic                   expire;
	logic                   out_free;
	logic                   can_put;
	logic                   put_due;
	logic [1:0]             put_freg;
	logic                   fin_push;
	logic [15:0]            ci;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_KEYS; gi++) begin : g_cell
			if (gi == NUM_KEYS - 1) begin : g_tail
				mpps_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.d_valid(wb_valid), .d_period(wb_period), .d_accum(wb_accum),
					.q_valid(cv[gi]), .q_period(cp[gi]), .q_accum(ca[gi])
				);
			end else begin : g_body
				mpps_cell #(.PERIOD_BITS(PERIOD_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.d_valid(cv[gi+1]), .d_period(cp[gi+1]), .d_accum(ca[gi+1]),
					.q_valid(cv[gi]), .q_period(cp[gi]), .q_accum(ca[gi])
				);
			end
		end
	endgenerate

	mpps_gcd #(.W(PERIOD_BITS)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gcd_start),
		.a(g_q), .b(wb_period),
		.busy(gcd_busy), .done(gcd_done), .result(gcd_result)
	);

	assign key_ok      = (int'(in_item.entry_key) < NUM_KEYS);
	assign in_per      = (PERIOD_BITS'(in_item.poll_period) == '0) ? PERIOD_BITS'(1)
	                   : PERIOD_BITS'(in_item.poll_period);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign tick_fire   = (elapsed_inc >= interval_q) && polling_q;
	assign idx_hit     = (int'(idx_q) == int'(key_q));
	assign fault_hit   = (int'(idx_q) == int'(fault_key_q));
	assign last_idx    = (idx_q == KW'(NUM_KEYS - 1));
	assign sum         = (PERIOD_BITS + 2)'(ca[0]) + (PERIOD_BITS + 2)'(add_q);
	assign sat_accum   = sum[PERIOD_BITS+1] ? ACCUM_MAX : sum[PERIOD_BITS:0];
	assign expire      = cv[0] && (sat_accum >= (PERIOD_BITS + 1)'(cp[0]));
	assign out_free    = !out_valid_q || out_ready;
	assign can_put     = !pend_valid_q || out_free;
	assign ci          = upd_int_q ? 16'(g_q) : 16'(interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		shift     = 1'b0;
		wb_valid  = cv[0];
		wb_period = cp[0];
		wb_accum  = ca[0];
		gcd_start = 1'b0;
		put_due   = 1'b0;
		put_freg  = mpps_pkg::FREG_NONE;
		fin_push  = 1'b0;
		case (state_q)
			mpps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (mpps_pkg::op_t'(in_item.op))
						mpps_pkg::OP_ADD:    state_d = key_ok ? mpps_pkg::ST_WALK
						                                      : mpps_pkg::ST_FINISH;
						mpps_pkg::OP_REMOVE: state_d = key_ok ? mpps_pkg::ST_WALK
						                                      : mpps_pkg::ST_FINISH;
						mpps_pkg::OP_TICK:   state_d = tick_fire ? mpps_pkg::ST_WALK
						                                         : mpps_pkg::ST_FINISH;
						default:             state_d = mpps_pkg::ST_FINISH;
					endcase
				end
			end
			mpps_pkg::ST_WALK: begin
				case (mpps_pkg::op_t'(op_q))
					mpps_pkg::OP_ADD: begin
						if (idx_hit) begin
							wb_valid  = 1'b1;
							wb_period = per_q;
							wb_accum  = '0;
						end
						shift = 1'b1;
						if (wb_valid && !first_q) begin
							gcd_start = 1'b1;
							state_d   = mpps_pkg::ST_GCD;
						end else if (last_idx) begin
							state_d = mpps_pkg::ST_FINISH;
						end
					end
					mpps_pkg::OP_REMOVE: begin
						if (idx_hit) begin
							wb_valid = 1'b0;
						end
						shift = 1'b1;
						if (last_idx) begin
							state_d = mpps_pkg::ST_FINISH;
						end
					end
					mpps_pkg::OP_TICK: begin
						if (expire) begin
							wb_accum = '0;
							if (can_put) begin
								put_due  = 1'b1;
								put_freg = fault_hit ? sub_q : mpps_pkg::FREG_NONE;
								shift    = !fault_hit || (sub_q == mpps_pkg::FREG_3);
							end
						end else begin
							if (cv[0]) begin
								wb_accum = sat_accum;
							end
							shift = 1'b1;
						end
						if (shift && last_idx) begin
							state_d = mpps_pkg::ST_FINISH;
						end
					end
					default: state_d = mpps_pkg::ST_FINISH;
				endcase
			end
			mpps_pkg::ST_GCD: begin
				if (gcd_done) begin
					state_d = walk_end_q ? mpps_pkg::ST_FINISH : mpps_pkg::ST_WALK;
				end
			end
			mpps_pkg::ST_FINISH: begin
				if (out_free) begin
					fin_push = 1'b1;
					state_d  = mpps_pkg::ST_IDLE;
				end
			end
			default: state_d = mpps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			sub_q        <= mpps_pkg::FREG_1;
			first_q      <= 1'b1;
			walk_end_q   <= 1'b0;
			anyv_acc_q   <= 1'b0;
			any_valid_q  <= 1'b0;
			upd_int_q    <= 1'b0;
			polling_q    <= 1'b0;
			fault_key_q  <= '0;
			interval_q   <= PERIOD_BITS'(mpps_pkg::INTERVAL_RESET);
			elapsed_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_push || (put_due && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_valid && in_ready) begin
				idx_q      <= '0;
				sub_q      <= mpps_pkg::FREG_1;
				first_q    <= 1'b1;
				anyv_acc_q <= 1'b0;
				upd_int_q  <= (mpps_pkg::op_t'(in_item.op) == mpps_pkg::OP_ADD) && key_ok;
				if (mpps_pkg::op_t'(in_item.op) == mpps_pkg::OP_TICK) begin
					elapsed_q <= (elapsed_inc >= interval_q) ? '0 : elapsed_inc;
				end
			end
			if (shift) begin
				idx_q      <= idx_q + 1'b1;
				walk_end_q <= last_idx;
				anyv_acc_q <= anyv_acc_q | wb_valid;
				if (wb_valid) begin
					first_q <= 1'b0;
				end
				if (last_idx) begin
					any_valid_q <= anyv_acc_q | wb_valid;
				end
			end
			if (put_due) begin
				pend_valid_q <= 1'b1;
				if (fault_hit && (sub_q != mpps_pkg::FREG_3)) begin
					sub_q <= sub_q + 1'b1;
				end else begin
					sub_q <= mpps_pkg::FREG_1;
				end
			end
			if (fin_push) begin
				pend_valid_q <= 1'b0;
				upd_int_q    <= 1'b0;
				if (upd_int_q) begin
					interval_q <= g_q;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mpps_pkg::CFG_POLLING_ENABLED: polling_q <= cfg_data[0];
					mpps_pkg::CFG_INITIAL_INTERVAL: begin
						if (!any_valid_q) begin
							interval_q <= (cfg_data == '0) ? PERIOD_BITS'(1)
							                               : PERIOD_BITS'(cfg_data);
						end
					end
					mpps_pkg::CFG_FAULT_STATE_KEY: fault_key_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_item.op;
			key_q <= in_item.entry_key;
			per_q <= in_per;
			add_q <= elapsed_inc;
		end
		if (shift && wb_valid && first_q) begin
			g_q <= wb_period;
		end
		if (gcd_done) begin
			g_q <= gcd_result;
		end
		if (put_due) begin
			pend_key_q  <= 4'(idx_q);
			pend_freg_q <= put_freg;
			if (pend_valid_q) begin
				out_item_q.due            <= 1'b1;
				out_item_q.due_key        <= pend_key_q;
				out_item_q.fault_register <= pend_freg_q;
				out_item_q.check_interval <= ci;
				out_item_q.last           <= 1'b0;
			end
		end
		if (fin_push) begin
			out_item_q.due            <= pend_valid_q;
			out_item_q.due_key        <= pend_valid_q ? pend_key_q : 4'd0;
			out_item_q.fault_register <= pend_valid_q ? pend_freg_q : mpps_pkg::FREG_NONE;
			out_item_q.check_interval <= ci;
			out_item_q.last           <= 1'b1;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpps_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("Pending item left over in idle.");

	a_gcd_state: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_busy |-> (state_q == mpps_pkg::ST_GCD))
		else $error("GCD unit running outside its state.");

	a_sub_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_q != mpps_pkg::FREG_1) |-> (state_q == mpps_pkg::ST_WALK))
		else $error("Fault sequence interrupted.");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(put_due && pend_valid_q) |-> out_free)
		else $error("Due item pushed over an unsent item.");

endmodule
